// File: rtl/core/assert_macros.svh
// assertion macros shared by the matcher rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SCM_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on the cycle after a trigger
`define SCM_ASSERT_NEXT(name, clk, rst, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// File: rtl/core/scm_pkg.sv
// shared types and constants of the serial command line matcher
// no dependencies; imported by every module of the block
`default_nettype none

package scm_pkg;

  localparam int LINE_CHARS_DEF    = 32;
  localparam int COMMAND_SLOTS_DEF = 16;

  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int INDEX_W  = 4;
  localparam int CFG_IDX_W = 2;

  // input tdata layout, lowest bit first
  localparam int IN_TDATA_W  = 32;
  localparam int IN_BYTE_LO  = 0;
  localparam int IN_SLOT_LO  = IN_BYTE_LO + BYTE_W;
  localparam int IN_POS_LO   = IN_SLOT_LO + SLOT_W;
  localparam int IN_CHAR_LO  = IN_POS_LO + POS_W;
  localparam int OUT_TDATA_W = 8;

  localparam logic OP_RX    = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 2'd2;

  localparam logic [BYTE_W-1:0]  TERMINATOR_RST = 8'h0D;
  localparam logic [BYTE_W-1:0]  DELIMITER_RST  = 8'h20;
  localparam logic [COUNT_W-1:0] COUNT_RST      = 5'd0;

  typedef struct packed {
    logic [BYTE_W-1:0]  terminator;
    logic [BYTE_W-1:0]  delimiter;
    logic [COUNT_W-1:0] command_count;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [BYTE_W-1:0]  rx_byte;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   position;
    logic [BYTE_W-1:0]  table_char;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic               matched;
    logic [INDEX_W-1:0] command_index;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/serial_command_line_matcher.sv
// serial command line matcher
// Byte stream in on s_axis, one result beat out on m_axis per terminated line
// holding a word. s_axis_tuser[0] selects a received byte (0) or a command
// table character write (1). Table writes and ordinary bytes leave the block
// idle and ready for the next beat. A terminator byte walks the line buffer
// for the first word, one read of the line memory per character, and then the
// command table in slot order, one read of each memory per compared character,
// stopping a slot at its first mismatch. The result sits in an output
// register; a stalled receiver holds the block in its final step and no new
// beat is taken until the result is loaded into the output register. Reset
// restores terminator 0x0d, delimiter 0x20, command count 0 and an empty line;
// line and table memories are not cleared and table slots must be loaded before
// use. Configuration writes go through cfg_we, cfg_index, cfg_data.
// depends on scm_pkg, scm_line_ram, scm_cmd_ram, scm_seq
`default_nettype none

module serial_command_line_matcher #(
  parameter int LINE_CHARS    = scm_pkg::LINE_CHARS_DEF,
  parameter int COMMAND_SLOTS = scm_pkg::COMMAND_SLOTS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // rx_byte[7:0], slot[11:8], position[16:12], table_char[24:17], zero
  input  wire  [scm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation[0]
  input  wire  [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // matched[0], command_index[4:1], zero
  output logic [scm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  wire                               cfg_we,
  input  wire  [scm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [scm_pkg::BYTE_W-1:0]        cfg_data
);
  import scm_pkg::*;

  localparam int LW = $clog2(LINE_CHARS);
  localparam int SW = (COMMAND_SLOTS > 1) ? $clog2(COMMAND_SLOTS) : 1;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    out_busy;
  logic    out_matched;
  logic [INDEX_W-1:0] out_index;

  logic              line_we;
  logic [LW-1:0]     line_waddr;
  logic [BYTE_W-1:0] line_wdata;
  logic [LW-1:0]     line_raddr;
  logic [BYTE_W-1:0] line_rdata;
  logic              tbl_we;
  logic [SW-1:0]     tbl_wslot;
  logic [LW-1:0]     tbl_wpos;
  logic [BYTE_W-1:0] tbl_wdata;
  logic [SW-1:0]     tbl_rslot;
  logic [LW-1:0]     tbl_rpos;
  logic [BYTE_W-1:0] tbl_rdata;

  always_comb begin
    item.operation  = s_axis_tuser[0];
    item.rx_byte    = s_axis_tdata[IN_BYTE_LO +: BYTE_W];
    item.slot       = s_axis_tdata[IN_SLOT_LO +: SLOT_W];
    item.position   = s_axis_tdata[IN_POS_LO +: POS_W];
    item.table_char = s_axis_tdata[IN_CHAR_LO +: BYTE_W];
    out_busy        = m_axis_tvalid && !m_axis_tready;
    m_axis_tdata    = {{(OUT_TDATA_W - INDEX_W - 1){1'b0}}, out_index, out_matched};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.terminator    <= TERMINATOR_RST;
      cfg.delimiter     <= DELIMITER_RST;
      cfg.command_count <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TERMINATOR: cfg.terminator    <= cfg_data;
        CFG_DELIMITER:  cfg.delimiter     <= cfg_data;
        CFG_COUNT:      cfg.command_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_matched <= res.matched;
      out_index   <= res.command_index;
    end
  end

  scm_seq #(
    .LINE_CHARS    (LINE_CHARS),
    .COMMAND_SLOTS (COMMAND_SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_item    (item),
    .in_ready   (s_axis_tready),
    .out_busy   (out_busy),
    .res        (res),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .line_wdata (line_wdata),
    .line_raddr (line_raddr),
    .line_rdata (line_rdata),
    .tbl_we     (tbl_we),
    .tbl_wslot  (tbl_wslot),
    .tbl_wpos   (tbl_wpos),
    .tbl_wdata  (tbl_wdata),
    .tbl_rslot  (tbl_rslot),
    .tbl_rpos   (tbl_rpos),
    .tbl_rdata  (tbl_rdata)
  );

  scm_line_ram #(
    .LINE_CHARS (LINE_CHARS)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  scm_cmd_ram #(
    .LINE_CHARS    (LINE_CHARS),
    .COMMAND_SLOTS (COMMAND_SLOTS)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (tbl_we),
    .wslot (tbl_wslot),
    .wpos  (tbl_wpos),
    .wdata (tbl_wdata),
    .rslot (tbl_rslot),
    .rpos  (tbl_rpos),
    .rdata (tbl_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/scm_line_ram.sv
// line buffer memory: one write port, one registered read port
// depends on scm_pkg
`default_nettype none

module scm_line_ram #(
  parameter int LINE_CHARS = scm_pkg::LINE_CHARS_DEF
) (
  input  wire                              clk,
  input  wire                              we,
  input  wire  [$clog2(LINE_CHARS)-1:0]    waddr,
  input  wire  [scm_pkg::BYTE_W-1:0]       wdata,
  input  wire  [$clog2(LINE_CHARS)-1:0]    raddr,
  output logic [scm_pkg::BYTE_W-1:0]       rdata
);
  import scm_pkg::*;

  logic [BYTE_W-1:0] mem [LINE_CHARS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/scm_cmd_ram.sv
// command table memory, slot by character, registered read port
// depends on scm_pkg
`default_nettype none

module scm_cmd_ram #(
  parameter int LINE_CHARS    = scm_pkg::LINE_CHARS_DEF,
  parameter int COMMAND_SLOTS = scm_pkg::COMMAND_SLOTS_DEF,
  localparam int LW = $clog2(LINE_CHARS),
  localparam int SW = (COMMAND_SLOTS > 1) ? $clog2(COMMAND_SLOTS) : 1
) (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [SW-1:0]               wslot,
  input  wire  [LW-1:0]               wpos,
  input  wire  [scm_pkg::BYTE_W-1:0]  wdata,
  input  wire  [SW-1:0]               rslot,
  input  wire  [LW-1:0]               rpos,
  output logic [scm_pkg::BYTE_W-1:0]  rdata
);
  import scm_pkg::*;

  logic [BYTE_W-1:0] mem [COMMAND_SLOTS][LINE_CHARS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wslot][wpos] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rslot][rpos];
  end

endmodule

`default_nettype wire

// File: rtl/core/scm_seq.sv
// sequencer: line append, word scan and table compare over the two memories
// depends on scm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module scm_seq #(
  parameter int LINE_CHARS    = scm_pkg::LINE_CHARS_DEF,
  parameter int COMMAND_SLOTS = scm_pkg::COMMAND_SLOTS_DEF,
  localparam int LW = $clog2(LINE_CHARS),
  localparam int SW = (COMMAND_SLOTS > 1) ? $clog2(COMMAND_SLOTS) : 1
) (
  input  wire                         clk,
  input  wire                         rst,
  input  scm_pkg::cfg_t               cfg,
  input  wire                         in_valid,
  input  scm_pkg::item_t              in_item,
  output logic                        in_ready,
  input  wire                         out_busy,
  output scm_pkg::result_t            res,
  output logic                        line_we,
  output logic [LW-1:0]               line_waddr,
  output logic [scm_pkg::BYTE_W-1:0]  line_wdata,
  output logic [LW-1:0]               line_raddr,
  input  wire  [scm_pkg::BYTE_W-1:0]  line_rdata,
  output logic                        tbl_we,
  output logic [SW-1:0]               tbl_wslot,
  output logic [LW-1:0]               tbl_wpos,
  output logic [scm_pkg::BYTE_W-1:0]  tbl_wdata,
  output logic [SW-1:0]               tbl_rslot,
  output logic [LW-1:0]               tbl_rpos,
  input  wire  [scm_pkg::BYTE_W-1:0]  tbl_rdata
);
  import scm_pkg::*;

  localparam int CW = $clog2(COMMAND_SLOTS + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CK  = 9'b000000100,
    S_FIND_RD  = 9'b000001000,
    S_FIND_CK  = 9'b000010000,
    S_SETUP    = 9'b000100000,
    S_MATCH_RD = 9'b001000000,
    S_MATCH_CK = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  function automatic logic is_printable(input logic [BYTE_W-1:0] b);
    return (b >= 8'h20) && (b <= 8'h7E);
  endfunction

  state_t            state;
  logic [LW-1:0]     len_q;
  logic [LW-1:0]     end_q;
  logic [LW-1:0]     idx_q;
  logic [LW-1:0]     start_q;
  logic [LW-1:0]     wlen_q;
  logic [LW-1:0]     k_q;
  logic [CW-1:0]     slot_q;
  logic              found_q;
  logic [BYTE_W-1:0] byte_q;
  logic              byte_printable_q;

  logic          accept;
  logic          is_term;
  logic          tbl_in_range;
  logic [LW-1:0] idx_inc;
  logic [CW-1:0] slot_inc;
  logic [CW-1:0] limit;

  always_comb begin
    in_ready     = (state == S_IDLE);
    accept       = in_valid && in_ready;
    is_term      = (in_item.operation == OP_RX) && (in_item.rx_byte == cfg.terminator);
    tbl_in_range = (int'(in_item.slot) < COMMAND_SLOTS) &&
                   (int'(in_item.position) < LINE_CHARS);
    idx_inc      = idx_q + 1'b1;
    slot_inc     = slot_q + 1'b1;
    if (int'(cfg.command_count) > COMMAND_SLOTS) begin
      limit = CW'(COMMAND_SLOTS);
    end else begin
      limit = CW'(cfg.command_count);
    end

    tbl_we    = accept && (in_item.operation == OP_TABLE) && tbl_in_range;
    tbl_wslot = SW'(in_item.slot);
    tbl_wpos  = LW'(in_item.position);
    tbl_wdata = in_item.table_char;
    tbl_rslot = SW'(slot_q);
    tbl_rpos  = k_q;

    line_we    = 1'b0;
    line_waddr = len_q;
    line_wdata = in_item.rx_byte;
    if (accept && (in_item.operation == OP_RX) && !is_term && is_printable(in_item.rx_byte)) begin
      line_we = 1'b1;
    end
    // printable terminator opens the next line once the result has gone out
    if ((state == S_DONE) && !out_busy && byte_printable_q) begin
      line_we    = 1'b1;
      line_waddr = '0;
      line_wdata = byte_q;
    end
    line_raddr = (state == S_MATCH_RD) ? LW'(start_q + k_q) : idx_q;

    res.valid         = (state == S_DONE) && !out_busy;
    res.matched       = found_q;
    res.command_index = found_q ? INDEX_W'(slot_q) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len_q <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (in_item.operation == OP_RX)) begin
            if (!is_term) begin
              if (is_printable(in_item.rx_byte)) begin
                len_q <= (len_q == LW'(LINE_CHARS - 1)) ? '0 : LW'(len_q + 1'b1);
              end
            end else begin
              end_q            <= len_q;
              len_q            <= '0;
              idx_q            <= '0;
              byte_q           <= in_item.rx_byte;
              byte_printable_q <= is_printable(in_item.rx_byte);
              if (len_q != '0) begin
                state <= S_SCAN_RD;
              end
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CK;
        S_SCAN_CK: begin
          idx_q <= idx_inc;
          if (line_rdata == cfg.delimiter) begin
            // only delimiters in the line: no word, no beat
            state <= (idx_inc == end_q) ? S_IDLE : S_SCAN_RD;
          end else begin
            start_q <= idx_q;
            state   <= (idx_inc == end_q) ? S_SETUP : S_FIND_RD;
          end
        end
        S_FIND_RD: state <= S_FIND_CK;
        S_FIND_CK: begin
          if (line_rdata == cfg.delimiter) begin
            state <= S_SETUP;
          end else begin
            idx_q <= idx_inc;
            state <= (idx_inc == end_q) ? S_SETUP : S_FIND_RD;
          end
        end
        S_SETUP: begin
          wlen_q  <= idx_q - start_q;
          slot_q  <= '0;
          k_q     <= '0;
          found_q <= 1'b0;
          state   <= (limit == '0) ? S_DONE : S_MATCH_RD;
        end
        S_MATCH_RD: state <= S_MATCH_CK;
        S_MATCH_CK: begin
          if ((k_q == wlen_q) && (tbl_rdata == '0)) begin
            found_q <= 1'b1;
            state   <= S_DONE;
          end else if ((k_q == wlen_q) || (tbl_rdata != line_rdata)) begin
            slot_q <= slot_inc;
            k_q    <= '0;
            state  <= (slot_inc == limit) ? S_DONE : S_MATCH_RD;
          end else begin
            k_q   <= k_q + 1'b1;
            state <= S_MATCH_RD;
          end
        end
        S_DONE: begin
          if (!out_busy) begin
            state <= S_IDLE;
            if (byte_printable_q) begin
              len_q <= LW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SCM_ASSERT(a_tbl_write_on_beat, clk, rst, tbl_we |-> accept, "table write without input beat")
  `SCM_ASSERT(a_scan_in_line, clk, rst, ((state == S_SCAN_CK) || (state == S_FIND_CK)) |-> (idx_q < end_q), "scan beyond line end")
  `SCM_ASSERT(a_match_in_word, clk, rst, (state == S_MATCH_CK) |-> (k_q <= wlen_q), "compare beyond word end")
  `SCM_ASSERT_NEXT(a_idle_after_result, clk, rst, res.valid, (state == S_IDLE), "sequencer busy after result")

endmodule

`default_nettype wire
